### src/nlfr_pkg.sv
// Shared types and constants for the nibble link frame receiver.
`default_nettype none

package nlfr_pkg;

	// Status and data line widths, plus nibble, byte, count and configuration widths
	localparam int unsigned LineW = 5;
	localparam int unsigned NibW  = 4;
	localparam int unsigned ByteW = 8;
	localparam int unsigned CntW  = 16;
	localparam int unsigned CfgW  = 16;
	localparam int unsigned CfgIdxW = 1;

	// Line patterns
	localparam logic [LineW-1:0] SofPattern = 5'h18;
	localparam logic [LineW-1:0] AckIdle    = 5'h00;
	localparam logic [LineW-1:0] AckSof     = 5'h01;
	localparam logic [LineW-1:0] AckLow     = 5'h10;
	localparam int unsigned      BusyBit    = 4;

	// Configuration register indexes and reset values
	localparam logic [CfgIdxW-1:0] CfgCapacity = 1'b0;
	localparam logic [CfgIdxW-1:0] CfgTimeout  = 1'b1;
	localparam logic [CfgW-1:0]    CapacityReset = 16'd256;
	localparam logic [CfgW-1:0]    TimeoutReset  = 16'd1000;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_LOW  = 2'd1,
		PH_HIGH = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ROLE_LEN_LO  = 2'd0,
		ROLE_LEN_HI  = 2'd1,
		ROLE_PAYLOAD = 2'd2,
		ROLE_CKSUM   = 2'd3
	} role_t;

	typedef struct packed {
		logic [LineW-1:0] data_lines;
		logic             byte_valid;
		logic [ByteW-1:0] byte_value;
		logic [CntW-1:0]  byte_position;
		logic             frame_done;
		logic             frame_error;
		logic [CntW-1:0]  frame_length;
		logic             checksum_ok;
	} result_t;

	typedef struct packed {
		logic [CfgW-1:0] capacity;
		logic [CfgW-1:0] timeout;
	} cfg_t;

endpackage

`default_nettype wire

### src/nlfr_if.sv
// Valid/ready channel interfaces for status samples and receiver results.
`default_nettype none

interface nlfr_sample_if;
	logic                           valid;
	logic                           ready;
	logic [nlfr_pkg::LineW-1:0]     status_lines;

	modport source (output valid, output status_lines, input ready);
	modport sink   (input valid, input status_lines, output ready);
endinterface

interface nlfr_result_if;
	logic                           valid;
	logic                           ready;
	logic [nlfr_pkg::LineW-1:0]     data_lines;
	logic                           byte_valid;
	logic [nlfr_pkg::ByteW-1:0]     byte_value;
	logic [nlfr_pkg::CntW-1:0]      byte_position;
	logic                           frame_done;
	logic                           frame_error;
	logic [nlfr_pkg::CntW-1:0]      frame_length;
	logic                           checksum_ok;

	modport source (
		output valid, output data_lines, output byte_valid, output byte_value,
		output byte_position, output frame_done, output frame_error,
		output frame_length, output checksum_ok, input ready
	);
	modport sink (
		input valid, input data_lines, input byte_valid, input byte_value,
		input byte_position, input frame_done, input frame_error,
		input frame_length, input checksum_ok, output ready
	);
endinterface

`default_nettype wire

### src/nlfr_cfg_regs.sv
// Configuration registers: buffer capacity and nibble timeout.
`default_nettype none

module nlfr_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [nlfr_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [nlfr_pkg::CfgW-1:0]     cfg_wdata,
	output nlfr_pkg::cfg_t                     cfg
);

	logic [nlfr_pkg::CfgW-1:0] capacity_q;
	logic [nlfr_pkg::CfgW-1:0] timeout_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= nlfr_pkg::CapacityReset;
			timeout_q  <= nlfr_pkg::TimeoutReset;
		end else if (cfg_we) begin
			case (cfg_index)
				nlfr_pkg::CfgCapacity: capacity_q <= cfg_wdata;
				nlfr_pkg::CfgTimeout:  timeout_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg.capacity = capacity_q;
	assign cfg.timeout  = timeout_q;

endmodule

`default_nettype wire

### src/nlfr_rx_core.sv
// Frame state machine: nibble capture, byte assembly, length, payload, checksum and nibble timeout.
`default_nettype none

module nlfr_rx_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic [nlfr_pkg::LineW-1:0]  sample,
	input  wire nlfr_pkg::cfg_t              cfg,
	output nlfr_pkg::result_t                result
);

	nlfr_pkg::phase_t phase_q, phase_d;
	nlfr_pkg::role_t  role_q, role_d;
	logic [nlfr_pkg::CntW-1:0]  len_q, len_d;
	logic [nlfr_pkg::CntW-1:0]  rcvd_q, rcvd_d;
	logic [nlfr_pkg::ByteW-1:0] sum_q, sum_d;
	logic [nlfr_pkg::NibW-1:0]  low_q, low_d;
	logic [nlfr_pkg::LineW-1:0] prev_q;
	logic [nlfr_pkg::CntW-1:0]  wait_q, wait_d;
	logic [nlfr_pkg::LineW-1:0] drive_q, drive_d;

	logic stable, busy, waiting, timeout_hit, take_low, take_high, sof;
	logic [nlfr_pkg::ByteW-1:0] rx_byte;
	logic [nlfr_pkg::CntW-1:0]  len_full, rcvd_inc;

	// events of this tick
	assign stable      = (sample == prev_q);
	assign busy        = sample[nlfr_pkg::BusyBit];
	assign waiting     = (phase_q == nlfr_pkg::PH_LOW) || (phase_q == nlfr_pkg::PH_HIGH);
	assign timeout_hit = waiting && (wait_q >= cfg.timeout);
	assign take_low    = !timeout_hit && (phase_q == nlfr_pkg::PH_LOW) && !busy && stable;
	assign take_high   = !timeout_hit && (phase_q == nlfr_pkg::PH_HIGH) && busy && stable;
	assign sof         = !waiting && (sample == nlfr_pkg::SofPattern);
	assign rx_byte     = {sample[nlfr_pkg::NibW-1:0], low_q};
	assign len_full    = {rx_byte, len_q[nlfr_pkg::ByteW-1:0]};
	assign rcvd_inc    = rcvd_q + 1'b1;

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			nlfr_pkg::PH_LOW, nlfr_pkg::PH_HIGH: begin
				if (timeout_hit) begin
					phase_d = nlfr_pkg::PH_IDLE;
				end else if (take_low) begin
					phase_d = nlfr_pkg::PH_HIGH;
				end else if (take_high) begin
					phase_d = (role_q == nlfr_pkg::ROLE_CKSUM) ? nlfr_pkg::PH_IDLE
					                                           : nlfr_pkg::PH_LOW;
				end
			end
			default: begin
				phase_d = sof ? nlfr_pkg::PH_LOW : nlfr_pkg::PH_IDLE;
			end
		endcase
	end

	// datapath updates and result
	always_comb begin
		role_d  = role_q;
		len_d   = len_q;
		rcvd_d  = rcvd_q;
		sum_d   = sum_q;
		low_d   = low_q;
		wait_d  = wait_q;
		drive_d = drive_q;
		result  = '0;
		if (waiting) begin
			if (timeout_hit) begin
				result.frame_error  = 1'b1;
				result.frame_length = len_q;
				drive_d = nlfr_pkg::AckIdle;
			end else if (take_low) begin
				low_d   = sample[nlfr_pkg::NibW-1:0];
				drive_d = nlfr_pkg::AckLow;
				wait_d  = '0;
			end else if (take_high) begin
				drive_d = nlfr_pkg::AckIdle;
				wait_d  = '0;
				case (role_q)
					nlfr_pkg::ROLE_LEN_LO: begin
						len_d  = {{(nlfr_pkg::CntW-nlfr_pkg::ByteW){1'b0}}, rx_byte};
						role_d = nlfr_pkg::ROLE_LEN_HI;
					end
					nlfr_pkg::ROLE_LEN_HI: begin
						len_d  = len_full;
						role_d = (len_full != '0) ? nlfr_pkg::ROLE_PAYLOAD
						                          : nlfr_pkg::ROLE_CKSUM;
					end
					nlfr_pkg::ROLE_PAYLOAD: begin
						if ((rcvd_q < len_q) && (rcvd_q < cfg.capacity)) begin
							result.byte_valid    = 1'b1;
							result.byte_value    = rx_byte;
							result.byte_position = rcvd_q;
						end
						sum_d  = sum_q + rx_byte;
						rcvd_d = rcvd_inc;
						if (rcvd_inc >= len_q) begin
							role_d = nlfr_pkg::ROLE_CKSUM;
						end
					end
					default: begin
						result.frame_done   = 1'b1;
						result.frame_length = len_q;
						result.checksum_ok  = (sum_q == rx_byte);
					end
				endcase
			end else if (wait_q != '1) begin
				wait_d = wait_q + 1'b1;
			end
		end else begin
			drive_d = nlfr_pkg::AckIdle;
			if (sof) begin
				drive_d = nlfr_pkg::AckSof;
				role_d  = nlfr_pkg::ROLE_LEN_LO;
				len_d   = '0;
				rcvd_d  = '0;
				sum_d   = '0;
				low_d   = '0;
				wait_d  = '0;
			end
		end
		result.data_lines = drive_d;
	end

	// state registers, advanced once per sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= nlfr_pkg::PH_IDLE;
			role_q  <= nlfr_pkg::ROLE_LEN_LO;
			len_q   <= '0;
			rcvd_q  <= '0;
			sum_q   <= '0;
			low_q   <= '0;
			prev_q  <= '0;
			wait_q  <= '0;
			drive_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			role_q  <= role_d;
			len_q   <= len_d;
			rcvd_q  <= rcvd_d;
			sum_q   <= sum_d;
			low_q   <= low_d;
			prev_q  <= sample;
			wait_q  <= wait_d;
			drive_q <= drive_d;
		end
	end

endmodule

`default_nettype wire

### src/nibble_link_frame_receiver.sv
// Top level of the nibble link frame receiver.
// A sample passes through the input register and then the result register before its result is offered.
// Throughput: one sample per cycle while the result side accepts; the frame state updates once per sample.
// Reset: arst_n clears both stage valids, the frame state (idle) and the configuration
// registers (capacity 256, timeout 1000) at once.
`default_nettype none

module nibble_link_frame_receiver (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	nlfr_sample_if.sink                        sample,
	nlfr_result_if.source                      result,
	input  wire logic                          cfg_we,
	input  wire logic [nlfr_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [nlfr_pkg::CfgW-1:0]     cfg_wdata
);

	nlfr_pkg::cfg_t    cfg;
	nlfr_pkg::result_t step_res;
	nlfr_pkg::result_t res_s2;
	logic [nlfr_pkg::LineW-1:0] sample_s1;
	logic valid_s1_q, valid_s2_q;
	logic adv_s1, take_in;

	assign adv_s1  = valid_s1_q && (!valid_s2_q || result.ready);
	assign take_in = sample.valid && sample.ready;
	assign sample.ready = !valid_s1_q || adv_s1;

	nlfr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	nlfr_rx_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.sample (sample_s1),
		.cfg    (cfg),
		.result (step_res)
	);

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
			valid_s2_q <= 1'b0;
		end else begin
			if (take_in) begin
				valid_s1_q <= 1'b1;
			end else if (adv_s1) begin
				valid_s1_q <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2_q <= 1'b1;
			end else if (result.ready) begin
				valid_s2_q <= 1'b0;
			end
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (take_in) begin
			sample_s1 <= sample.status_lines;
		end
		if (adv_s1) begin
			res_s2 <= step_res;
		end
	end

	assign result.valid         = valid_s2_q;
	assign result.data_lines    = res_s2.data_lines;
	assign result.byte_valid    = res_s2.byte_valid;
	assign result.byte_value    = res_s2.byte_value;
	assign result.byte_position = res_s2.byte_position;
	assign result.frame_done    = res_s2.frame_done;
	assign result.frame_error   = res_s2.frame_error;
	assign result.frame_length  = res_s2.frame_length;
	assign result.checksum_ok   = res_s2.checksum_ok;

endmodule

`default_nettype wire

### src/nlfr_checker.sv
// Port-level checks for the receiver, bound to the top level.
`default_nettype none

module nlfr_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic [nlfr_pkg::LineW-1:0]   data_lines,
	input wire logic                         byte_valid,
	input wire logic [nlfr_pkg::ByteW-1:0]   byte_value,
	input wire logic [nlfr_pkg::CntW-1:0]    byte_position,
	input wire logic                         frame_done,
	input wire logic                         frame_error,
	input wire logic                         checksum_ok
);

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a frame cannot both finish and abort, nor emit a byte at that transfer
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(frame_done && frame_error) && !(byte_valid && (frame_done || frame_error)))
		else $error("conflicting frame events");

	// byte fields are clear without a byte
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> byte_value == '0 && byte_position == '0)
		else $error("byte fields set without a byte");

	// checksum flag only with frame completion
	a_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && checksum_ok |-> frame_done)
		else $error("checksum_ok outside frame_done");

	// only idle, start and low-nibble acknowledges are driven
	a_ack: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> data_lines == nlfr_pkg::AckIdle || data_lines == nlfr_pkg::AckSof
			|| data_lines == nlfr_pkg::AckLow)
		else $error("unexpected data line value");

endmodule

bind nibble_link_frame_receiver nlfr_checker u_nlfr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.data_lines    (result.data_lines),
	.byte_valid    (result.byte_valid),
	.byte_value    (result.byte_value),
	.byte_position (result.byte_position),
	.frame_done    (result.frame_done),
	.frame_error   (result.frame_error),
	.checksum_ok   (result.checksum_ok)
);

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the nibble link frame receiver.
`timescale 1ns / 1ps

module tb_top;
	import nlfr_pkg::*;

	localparam int DrainCycles = 4;
	localparam int StallCycles = 80;
	localparam int WatchdogLimit = 3000;
	localparam int MaxReports = 50;

	// Frame receiver predictor and store of expected results
	class rx_scoreboard;
		logic [CfgW-1:0]  capacity;
		logic [CfgW-1:0]  timeout;
		phase_t           ph;
		role_t            role;
		logic [CntW-1:0]  ann_len;
		logic [CntW-1:0]  rx_count;
		logic [CntW-1:0]  wait_cnt;
		logic [ByteW-1:0] sum;
		logic [NibW-1:0]  lo_nib;
		logic [LineW-1:0] prev;
		logic [LineW-1:0] drive;
		result_t          due_results[$];
		int               errors;

		function new();
			capacity = CapacityReset;
			timeout  = TimeoutReset;
			ph       = PH_IDLE;
			role     = ROLE_LEN_LO;
			ann_len  = '0;
			rx_count = '0;
			wait_cnt = '0;
			sum      = '0;
			lo_nib   = '0;
			prev     = '0;
			drive    = AckIdle;
			errors   = 0;
		endfunction

		function bit is_idle();
			return ph != PH_LOW && ph != PH_HIGH;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		// Advance the receiver by one status sample and queue its result
		function void take_sample(input logic [LineW-1:0] s);
			result_t          r;
			bit               stable;
			bit               busy;
			logic [ByteW-1:0] b;
			r = '0;
			stable = (s == prev);
			busy = s[BusyBit];
			if (ph == PH_LOW || ph == PH_HIGH) begin
				if (wait_cnt >= timeout) begin
					// nibble wait expired: abort the frame
					r.frame_error = 1'b1;
					r.frame_length = ann_len;
					ph = PH_IDLE;
					drive = AckIdle;
				end else if (ph == PH_LOW && !busy && stable) begin
					lo_nib = s[NibW-1:0];
					drive = AckLow;
					ph = PH_HIGH;
					wait_cnt = '0;
				end else if (ph == PH_HIGH && busy && stable) begin
					b = {s[NibW-1:0], lo_nib};
					drive = AckIdle;
					ph = PH_LOW;
					wait_cnt = '0;
					case (role)
						ROLE_LEN_LO: begin
							ann_len = {8'h00, b};
							role = ROLE_LEN_HI;
						end
						ROLE_LEN_HI: begin
							ann_len[15:8] = b;
							role = (ann_len != 0) ? ROLE_PAYLOAD : ROLE_CKSUM;
						end
						ROLE_PAYLOAD: begin
							if (rx_count < ann_len && rx_count < capacity) begin
								r.byte_valid = 1'b1;
								r.byte_value = b;
								r.byte_position = rx_count;
							end
							sum = sum + b;
							rx_count = rx_count + 1'b1;
							if (rx_count >= ann_len)
								role = ROLE_CKSUM;
						end
						default: begin
							r.frame_done = 1'b1;
							r.frame_length = ann_len;
							r.checksum_ok = (sum == b);
							ph = PH_IDLE;
						end
					endcase
				end else if (wait_cnt != 16'hffff) begin
					wait_cnt = wait_cnt + 1'b1;
				end
			end else begin
				ph = PH_IDLE;
				drive = AckIdle;
				if (s == SofPattern) begin
					drive = AckSof;
					ph = PH_LOW;
					role = ROLE_LEN_LO;
					ann_len = '0;
					rx_count = '0;
					sum = '0;
					lo_nib = '0;
					wait_cnt = '0;
				end
			end
			prev = s;
			r.data_lines = drive;
			due_results.push_back(r);
		endfunction

		function void match(input string field, input logic [CntW-1:0] want,
				input logic [CntW-1:0] got);
			if (got !== want) begin
				if (errors < MaxReports)
					$display("%0t: %s mismatch: expected %0h, actual %0h",
						$time, field, want, got);
				errors++;
			end
		endfunction

		// Compare one result transfer with the oldest expectation
		function void check_result(input result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				if (errors < MaxReports)
					$display("%0t: unexpected result: expected none, actual %p", $time, got);
				errors++;
				return;
			end
			want = due_results.pop_front();
			match("data_lines", 16'(want.data_lines), 16'(got.data_lines));
			match("byte_valid", 16'(want.byte_valid), 16'(got.byte_valid));
			match("byte_value", 16'(want.byte_value), 16'(got.byte_value));
			match("byte_position", want.byte_position, got.byte_position);
			match("frame_done", 16'(want.frame_done), 16'(got.frame_done));
			match("frame_error", 16'(want.frame_error), 16'(got.frame_error));
			match("frame_length", want.frame_length, got.frame_length);
			match("checksum_ok", 16'(want.checksum_ok), 16'(got.checksum_ok));
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgW-1:0]     cfg_wdata;
	bit                  idle_on = 1'b1;
	bit                  stall_now = 1'b0;
	int                  n_sent = 0;
	int                  quiet_cycles = 0;
	result_t             got;
	rx_scoreboard        sb;

	nlfr_sample_if smp ();
	nlfr_result_if res ();

	nibble_link_frame_receiver i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (smp.sink),
		.result    (res.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Offer one sample and wait for its transfer
	task automatic put_sample(input logic [LineW-1:0] s);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 7);
			smp.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp.valid <= 1'b1;
		smp.status_lines <= s;
		@(posedge clk);
		while (smp.ready !== 1'b1) @(posedge clk);
		sb.take_sample(s);
		n_sent++;
	endtask

	// One byte as a low nibble (busy low) then a high nibble (busy high)
	task automatic send_byte(input logic [ByteW-1:0] b, input bit sloppy, input bit last);
		int hold;
		hold = $urandom_range(2, 4);
		if (sloppy && $urandom_range(0, 9) == 0)
			hold = 1;
		repeat (hold) put_sample({1'b0, b[3:0]});
		hold = $urandom_range(2, 4);
		if (sloppy && $urandom_range(0, 9) == 0)
			hold = 1;
		// repeats of a closing high nibble 8 would read as a new start pattern
		if (last && {1'b1, b[7:4]} == SofPattern && hold > 2)
			hold = 2;
		repeat (hold) put_sample({1'b1, b[7:4]});
		if (sloppy && $urandom_range(0, 11) == 0)
			put_sample(LineW'($urandom_range(0, 31)));
	endtask

	// Start pattern, header, payload and checksum; sloppy frames may be cut short
	task automatic send_frame(input bit sloppy, input int max_len);
		int               n_pre;
		int               len;
		int               n_body;
		logic [LineW-1:0] noise;
		logic [ByteW-1:0] b;
		logic [ByteW-1:0] total;
		logic [LineW-1:0] flush_val;
		n_pre = $urandom_range(0, 3);
		repeat (n_pre) begin
			do noise = LineW'($urandom_range(0, 31)); while (noise == SofPattern);
			put_sample(noise);
		end
		put_sample(SofPattern);
		len = $urandom_range(0, max_len);
		if (sloppy && $urandom_range(0, 4) == 0)
			len = $urandom_range(0, 65535);
		send_byte(len[7:0], sloppy, 1'b0);
		send_byte(len[15:8], sloppy, 1'b0);
		n_body = (len > 8) ? $urandom_range(0, 8) : len;
		total = '0;
		for (int i = 0; i < n_body; i++) begin
			b = ByteW'($urandom);
			total = total + b;
			send_byte(b, sloppy, 1'b0);
		end
		if (n_body == len)
			send_byte(($urandom_range(0, 3) == 0) ? ByteW'($urandom) : total, sloppy, 1'b1);
		// unstable samples until the nibble wait runs out
		flush_val = '0;
		while (!sb.is_idle()) begin
			put_sample(flush_val);
			flush_val = ~flush_val;
		end
	endtask

	task automatic send_frames(input int count, input bit sloppy, input int max_len);
		int start;
		start = n_sent;
		while (n_sent - start < count)
			send_frame(sloppy, max_len);
	endtask

	// Let every expected result arrive, then allow the pipeline to settle
	task automatic drain();
		smp.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic set_config(input logic [CfgW-1:0] cap, input logic [CfgW-1:0] tmo);
		cfg_we <= 1'b1;
		cfg_index <= CfgCapacity;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_index <= CfgTimeout;
		cfg_wdata <= tmo;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.capacity = cap;
		sb.timeout = tmo;
	endtask

	// Result side: random hold-offs plus one long stall on request
	initial begin
		int gap;
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_now) begin
				stall_now = 1'b0;
				res.ready <= 1'b0;
				repeat (StallCycles) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 7);
				res.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res.ready <= 1'b1;
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && res.valid === 1'b1 && res.ready === 1'b1) begin
			got.data_lines = res.data_lines;
			got.byte_valid = res.byte_valid;
			got.byte_value = res.byte_value;
			got.byte_position = res.byte_position;
			got.frame_done = res.frame_done;
			got.frame_error = res.frame_error;
			got.frame_length = res.frame_length;
			got.checksum_ok = res.checksum_ok;
			sb.check_result(got);
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((smp.valid === 1'b1 && smp.ready === 1'b1) ||
				(res.valid === 1'b1 && res.ready === 1'b1))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		sb = new();
		arst_n <= 1'b0;
		smp.valid <= 1'b0;
		smp.status_lines <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CfgCapacity;
		cfg_wdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: line extremes in idle, then an empty frame with a zero checksum
		put_sample(5'h00);
		put_sample(5'h1f);
		put_sample(SofPattern);
		repeat (3) begin
			put_sample(5'h00);
			put_sample(5'h00);
			put_sample(5'h10);
			put_sample(5'h10);
		end

		// Reset settings, with one long result stall
		stall_now = 1'b1;
		send_frames(80, 1'b0, 6);

		drain();
		set_config(16'd0, 16'hffff);
		send_frames(80, 1'b0, 6);

		drain();
		set_config(16'd3, 16'd12);
		send_frames(120, 1'b1, 8);

		drain();
		set_config(16'hffff, 16'd1);
		send_frames(30, 1'b1, 4);

		drain();
		set_config(16'd0, 16'd0);
		send_frames(20, 1'b1, 4);

		drain();
		set_config(CfgW'($urandom_range(1, 8)), 16'd30);
		send_frames(150, 1'b1, 8);

		// Final stretch without idling
		drain();
		idle_on = 1'b0;
		set_config(16'hffff, 16'hffff);
		send_frames(120, 1'b0, 8);

		drain();
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
